/* sv/gwps_pkg.sv */
package gwps_pkg;

  localparam int unsigned MAX_HISTORY_DEF = 16;
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned DEPTH_BITS      = 4;
  localparam int unsigned WEIGHT_BITS     = 17;
  localparam int unsigned FRAC_BITS       = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } gwps_state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic mul;
    logic acc;
    logic load;
  } gwps_cmd_t;

  typedef struct packed {
    logic rd_more;
    logic mac_done;
    logic out_free;
  } gwps_sts_t;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-8 i^2 / n^2) as Q0.16
  function automatic logic [63:0] raw_weight(input logic [63:0] i, input logic [63:0] n);
    logic [63:0] y;
    logic [63:0] h;
    y = udiv((i * i) << 26, n * n);
    h = 64'd1 << 31;
    for (int k = 6; k >= 1; k--) begin
      h = (64'd1 << 31) - udiv((y * h) >> 31, 64'(k));
    end
    for (int s = 0; s < 8; s++) begin
      h = (h * h + (64'd1 << 30)) >> 31;
    end
    return (h + (64'd1 << 14)) >> 15;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] gauss_weight(input int unsigned n,
                                                          input int unsigned i);
    logic [63:0] sum;
    logic [63:0] w;
    sum = '0;
    for (int unsigned j = 0; j < n; j++) begin
      sum = sum + raw_weight(64'(j), 64'(n));
    end
    if (i >= n || sum == 64'd0) begin
      w = '0;
    end else begin
      w = udiv((raw_weight(64'(i), 64'(n)) << 16) + (sum >> 1), sum);
    end
    return w[WEIGHT_BITS-1:0];
  endfunction

endpackage

/* sv/gwps_in_if.sv */
interface gwps_in_if import gwps_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

/* sv/gwps_out_if.sv */
interface gwps_out_if import gwps_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned CNT_W      = $clog2(MAX_HISTORY_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] filtered_x;
  logic signed [COORD_BITS-1:0] filtered_y;
  logic [CNT_W-1:0]             stored_count;

  modport source (output valid, output filtered_x, output filtered_y, output stored_count,
                  input ready);
  modport sink   (input valid, input filtered_x, input filtered_y, input stored_count,
                  output ready);
endinterface

/* sv/gaussian_weighted_position_smoother_unit.sv */
// Gaussian-weighted position smoother.
// in_req carries one touch position (pos_x, pos_y) per request. Each request is
// pushed onto a newest-first history of history_depth+1 entries (at most
// MAX_HISTORY), and out_req returns the Gaussian-weighted mean of the stored
// positions (filtered_x, filtered_y) and the number of entries held (stored_count).
// cfg_we/cfg_wdata write history_depth; write it only while the unit is idle.
// An accepted request reads the newest history entry, then runs the single
// multiply-accumulate loop, a multiply state and an add state per history
// entry (the RAM read of the next entry overlaps the multiply), and finally
// loads the result into the output register. The next request can be taken
// in the cycle after the result is loaded.
// out_req is fed from an output register: a new request is accepted while a
// result waits, and the unit holds its next result until out_req.ready frees
// that register.
// Reset clears history_depth and the entry count to zero; history contents
// are not cleared and never read before being written.
module gaussian_weighted_position_smoother_unit import gwps_pkg::*; #(
  parameter int unsigned MAX_HISTORY = MAX_HISTORY_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [DEPTH_BITS-1:0] cfg_wdata,
  gwps_in_if.sink               in_req,
  gwps_out_if.source            out_req
);

  gwps_cmd_t cmd;
  gwps_sts_t sts;

  gwps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gwps_datapath #(
    .MAX_HISTORY (MAX_HISTORY),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pos_x        (in_req.pos_x),
    .pos_y        (in_req.pos_y),
    .out_valid    (out_req.valid),
    .out_ready    (out_req.ready),
    .filtered_x   (out_req.filtered_x),
    .filtered_y   (out_req.filtered_y),
    .stored_count (out_req.stored_count),
    .cmd          (cmd),
    .sts          (sts)
  );

  ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while previous one still in progress");

  ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid |-> (out_req.stored_count != 0 && out_req.stored_count <= MAX_HISTORY))
    else $error("stored_count out of range");

  ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_req.valid && !out_req.ready))
    else $error("result loaded over a pending one");

  ap_start_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !(cmd.rd || cmd.mul || cmd.acc || cmd.load))
    else $error("new request started during accumulation");

endmodule

/* sv/gwps_ram.sv */
module gwps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* sv/gwps_ctrl.sv */
module gwps_ctrl import gwps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gwps_sts_t sts,
  output gwps_cmd_t cmd
);

  gwps_state_t state_r;
  gwps_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = sts.mac_done ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_READ: cmd.rd = 1'b1;
      ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.rd  = sts.rd_more;
      end
      ST_ACC:  cmd.acc = 1'b1;
      ST_DONE: cmd.load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* sv/gwps_datapath.sv */
module gwps_datapath import gwps_pkg::*; #(
  parameter int unsigned MAX_HISTORY = MAX_HISTORY_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [DEPTH_BITS-1:0]                 cfg_wdata,
  input  logic signed [COORD_BITS-1:0]          pos_x,
  input  logic signed [COORD_BITS-1:0]          pos_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_BITS-1:0]          filtered_x,
  output logic signed [COORD_BITS-1:0]          filtered_y,
  output logic [$clog2(MAX_HISTORY+1)-1:0]      stored_count,
  input  gwps_cmd_t                             cmd,
  output gwps_sts_t                             sts
);

  localparam int unsigned AW     = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_HISTORY + 1);
  localparam int unsigned LW     = (DEPTH_BITS > CNT_W) ? DEPTH_BITS + 1 : CNT_W + 1;
  localparam int unsigned PROD_W = COORD_BITS + WEIGHT_BITS + 1;
  localparam int unsigned ACC_W  = PROD_W + AW;
  localparam int unsigned Q_W    = ACC_W + 1 - FRAC_BITS;
  localparam logic signed [Q_W-1:0] Q_HI = (Q_W'(1) << (COORD_BITS - 1)) - Q_W'(1);
  localparam logic signed [Q_W-1:0] Q_LO = -(Q_W'(1) << (COORD_BITS - 1));

  logic [WEIGHT_BITS-1:0] weight_lut [MAX_HISTORY][MAX_HISTORY];

  for (genvar gn = 0; gn < MAX_HISTORY; gn++) begin : g_row
    for (genvar gi = 0; gi < MAX_HISTORY; gi++) begin : g_col
      localparam logic [WEIGHT_BITS-1:0] W = gauss_weight(gn + 1, gi);
      assign weight_lut[gn][gi] = W;
    end
  end

  logic [DEPTH_BITS-1:0]      depth_r;
  logic [AW-1:0]              head_r;
  logic [AW-1:0]              rd_ptr_r;
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           idx_r;
  logic [CNT_W-1:0]           mac_r;
  logic [WEIGHT_BITS-1:0]     w_r;
  logic signed [PROD_W-1:0]   prod_x_r;
  logic signed [PROD_W-1:0]   prod_y_r;
  logic signed [ACC_W-1:0]    acc_x_r;
  logic signed [ACC_W-1:0]    acc_y_r;
  logic                       out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic [CNT_W-1:0]           out_cnt_r;

  logic [AW-1:0]              head_nxt;
  logic [AW-1:0]              rd_ptr_dec;
  logic [LW-1:0]              lim;
  logic [LW-1:0]              lim_raw;
  logic [LW-1:0]              fill_inc;
  logic [CNT_W-1:0]           fill_nxt;
  logic [CNT_W-1:0]           row;
  logic [2*COORD_BITS-1:0]    rdata;
  logic signed [COORD_BITS-1:0] hist_x;
  logic signed [COORD_BITS-1:0] hist_y;

  assign head_nxt   = (head_r == AW'(MAX_HISTORY - 1)) ? '0 : head_r + AW'(1);
  assign rd_ptr_dec = (rd_ptr_r == '0) ? AW'(MAX_HISTORY - 1) : rd_ptr_r - AW'(1);
  assign lim_raw    = LW'(depth_r) + LW'(1);
  assign lim        = (lim_raw > LW'(MAX_HISTORY)) ? LW'(MAX_HISTORY) : lim_raw;
  assign fill_inc   = LW'(fill_r) + LW'(1);
  assign fill_nxt   = (fill_inc > lim) ? CNT_W'(lim) : CNT_W'(fill_inc);
  assign row        = fill_r - CNT_W'(1);
  assign hist_x     = rdata[2*COORD_BITS-1:COORD_BITS];
  assign hist_y     = rdata[COORD_BITS-1:0];

  gwps_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_HISTORY)
  ) u_hist (
    .clk     (clk),
    .we      (cmd.start),
    .waddr   (head_nxt),
    .wdata   ({pos_x, pos_y}),
    .re      (cmd.rd),
    .raddr   (rd_ptr_r),
    .rdata_r (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      head_r  <= '0;
      fill_r  <= '0;
    end else begin
      if (cfg_we) depth_r <= cfg_wdata;
      if (cmd.start) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      mac_r <= '0;
    end else if (cmd.start) begin
      idx_r <= '0;
      mac_r <= '0;
    end else begin
      if (cmd.rd)  idx_r <= idx_r + CNT_W'(1);
      if (cmd.mul) mac_r <= mac_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_ptr_r <= head_nxt;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
    end else begin
      if (cmd.rd) begin
        rd_ptr_r <= rd_ptr_dec;
        w_r      <= weight_lut[row[AW-1:0]][idx_r[AW-1:0]];
      end
      if (cmd.acc) begin
        acc_x_r <= acc_x_r + ACC_W'(prod_x_r);
        acc_y_r <= acc_y_r + ACC_W'(prod_y_r);
      end
    end
    if (cmd.mul) begin
      prod_x_r <= hist_x * $signed({1'b0, w_r});
      prod_y_r <= hist_y * $signed({1'b0, w_r});
    end
  end

  function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] rnd;
    logic signed [Q_W-1:0] q;
    rnd = (ACC_W + 1)'(a) + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
    q   = rnd[ACC_W:FRAC_BITS];
    if (q > Q_HI) begin
      return Q_HI[COORD_BITS-1:0];
    end else if (q < Q_LO) begin
      return Q_LO[COORD_BITS-1:0];
    end
    return q[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_x_r   <= round_sat(acc_x_r);
      out_y_r   <= round_sat(acc_y_r);
      out_cnt_r <= fill_r;
    end
  end

  assign sts.rd_more  = (idx_r != fill_r);
  assign sts.mac_done = (mac_r == fill_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign filtered_x   = out_x_r;
  assign filtered_y   = out_y_r;
  assign stored_count = out_cnt_r;

endmodule
